@@ rtl/core/npsp_pkg.sv @@
package npsp_pkg;

  localparam int AW = 136;
  localparam int SW = AW + 1;
  localparam int DW = 31;
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_TOP = 62;
  localparam logic [DW-1:0] DIST_SAT = '1;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD0, S_LD0, S_RDN, S_LDN, S_LA, S_LB, S_TA, S_TB,
    S_DA, S_DB, S_CA, S_CB, S_CC, S_CD, S_SQ, S_FX, S_FXD, S_FY, S_FYD,
    S_CMP, S_NEXT, S_DONE
  } npsp_state_t;

  typedef struct packed {
    logic          start;
    alu_op_t       op;
    logic [AW-1:0] a;
    logic [AW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic          done;
    logic [AW-1:0] res;
  } alu_rsp_t;

  function automatic logic [AW-1:0] mag(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] n;
    n = -v;
    return v[SW-1] ? n[AW-1:0] : v[AW-1:0];
  endfunction

endpackage

@@ rtl/core/npsp_in_if.sv @@
interface npsp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;

  modport source (output valid, output mode, output coord_x, output coord_y, input ready);
  modport sink (input valid, input mode, input coord_x, input coord_y, output ready);
endinterface

@@ rtl/core/npsp_out_if.sv @@
interface npsp_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic [7:0]         segment_index;
  logic [30:0]        distance;
  logic signed [31:0] nearest_x;
  logic signed [31:0] nearest_y;

  modport source (output valid, output found, output segment_index, output distance,
                  output nearest_x, output nearest_y, input ready);
  modport sink (input valid, input found, input segment_index, input distance,
                input nearest_x, input nearest_y, output ready);
endinterface

@@ rtl/core/npsp_alu.sv @@
module npsp_alu import npsp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  alu_op_t       op_r, op_nxt;
  logic [AW-1:0] x_r, x_nxt;
  logic [AW-1:0] y_r, y_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [AW-1:0] res_r, res_nxt;
  logic [7:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] rem_sh, rem_sub, sq_trial;
  logic          rem_ge, sq_ge;

  assign rem_sh   = {acc_r[AW-2:0], x_r[AW-1]};
  assign rem_ge   = rem_sh >= y_r;
  assign rem_sub  = rem_sh - y_r;
  assign sq_trial = acc_r + y_r;
  assign sq_ge    = x_r >= sq_trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    if (!busy_r) begin
      if (req.start) begin
        busy_nxt = 1'b1;
        op_nxt   = req.op;
        x_nxt    = req.a;
        y_nxt    = req.b;
        acc_nxt  = '0;
        cnt_nxt  = 8'(AW);
        if (req.op == OP_SQRT) begin
          y_nxt   = AW'(1) << SQRT_TOP;
          cnt_nxt = 8'(SQRT_STEPS);
        end
      end
    end else begin
      unique case (op_r)
        OP_MUL: begin
          if (y_r == '0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            res_nxt  = acc_r;
          end else begin
            if (y_r[0]) acc_nxt = acc_r + x_r;
            x_nxt = x_r << 1;
            y_nxt = y_r >> 1;
          end
        end
        OP_DIV: begin
          acc_nxt = rem_ge ? rem_sub : rem_sh;
          x_nxt   = {x_r[AW-2:0], rem_ge};
          cnt_nxt = cnt_r - 8'd1;
          if (cnt_r == 8'd1) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            res_nxt  = x_nxt;
          end
        end
        OP_SQRT: begin
          if (sq_ge) begin
            x_nxt   = x_r - sq_trial;
            acc_nxt = (acc_r >> 1) + y_r;
          end else begin
            acc_nxt = acc_r >> 1;
          end
          y_nxt   = y_r >> 2;
          cnt_nxt = cnt_r - 8'd1;
          if (cnt_r == 8'd1) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            res_nxt  = acc_nxt;
          end
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

@@ rtl/core/nearest_polyline_segment_point_core.sv @@
// Stores a polyline of up to MAX_VERTICES vertices and finds, for a query point, the
// nearest segment, its distance and the nearest point on it. Clear and append words
// are taken in the idle state. A query reads its first vertex, then for each segment
// reads the next vertex from memory and runs operations on one shared bit-serial
// unit: a multiply runs until no set bit of its second operand is left, a divide
// steps through every bit of its dividend and a square root yields one result bit
// per step. A segment whose nearest point is an endpoint needs no divide; one with
// an interior foot point needs three. A zero-length segment is skipped once its
// length is known. The finished result sits in an output register until it is taken;
// a new word is accepted only when the core is idle.
module nearest_polyline_segment_point_core import npsp_pkg::*; #(
  parameter int MAX_VERTICES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  npsp_in_if.sink   in_ch,
  npsp_out_if.source out_ch
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  npsp_state_t        state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic               pend_r, pend_nxt;
  logic               found_r, found_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic signed [31:0] x1_r, x1_nxt, y1_r, y1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;
  logic signed [31:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic signed [31:0] best_x_r, best_x_nxt, best_y_r, best_y_nxt;
  logic [AW-1:0]      len2_r, len2_nxt, val_r, val_nxt;
  logic signed [SW-1:0] sacc_r, sacc_nxt, t_r, t_nxt;
  logic               near2_r, near2_nxt, interior_r, interior_nxt;
  logic [DW-1:0]      d_r, d_nxt, best_d_r, best_d_nxt;
  logic [7:0]         best_i_r, best_i_nxt;
  logic               o_found_r, o_found_nxt;
  logic [7:0]         o_idx_r, o_idx_nxt;
  logic [DW-1:0]      o_dist_r, o_dist_nxt;
  logic signed [31:0] o_x_r, o_x_nxt, o_y_r, o_y_nxt;

  logic [63:0]        vmem [MAX_VERTICES];
  logic [63:0]        rd_data_r;
  logic               rd_en, wr_en;
  logic [IW-1:0]      rd_addr;

  alu_req_t           req;
  alu_rsp_t           rsp;
  logic               is_op, neg;
  logic signed [SW-1:0] ux, uy, wx, wy, vx, vy, dx, dy, pv, sp, tsum;
  logic [AW-1:0]      lsum;
  logic [CW:0]        ip2;
  logic               sq_sat, accept;
  logic signed [33:0] foot_off, foot_sum;
  logic signed [31:0] foot_base;
  logic               foot_neg;

  npsp_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign ux = SW'(x2_r) - SW'(x1_r);
  assign uy = SW'(y2_r) - SW'(y1_r);
  assign wx = SW'(qx_r) - SW'(x1_r);
  assign wy = SW'(qy_r) - SW'(y1_r);
  assign vx = SW'(qx_r) - SW'(x2_r);
  assign vy = SW'(qy_r) - SW'(y2_r);
  assign dx = near2_r ? vx : wx;
  assign dy = near2_r ? vy : wy;
  assign pv = {1'b0, rsp.res};
  assign sp = neg ? -pv : pv;
  assign tsum = sacc_r + sp;
  assign lsum = len2_r + rsp.res;
  assign ip2 = {1'b0, i_r} + (CW+1)'(2);
  assign sq_sat = |val_r[AW-1:SQRT_TOP];
  assign accept = in_ch.valid && in_ch.ready;

  assign foot_base = (state_r == S_FYD) ? y1_r : x1_r;
  assign foot_neg  = (state_r == S_FYD) ? uy[SW-1] : ux[SW-1];
  assign foot_off  = foot_neg ? -{1'b0, rsp.res[32:0]} : {1'b0, rsp.res[32:0]};
  assign foot_sum  = 34'(foot_base) + foot_off;

  always_comb begin
    is_op  = 1'b1;
    neg    = 1'b0;
    req.op = OP_MUL;
    req.a  = '0;
    req.b  = '0;
    unique case (state_r)
      S_LA:  begin req.a = mag(ux); req.b = mag(ux); end
      S_LB:  begin req.a = mag(uy); req.b = mag(uy); end
      S_TA:  begin req.a = mag(wx); req.b = mag(ux); neg = wx[SW-1] ^ ux[SW-1]; end
      S_TB:  begin req.a = mag(wy); req.b = mag(uy); neg = wy[SW-1] ^ uy[SW-1]; end
      S_DA:  begin req.a = mag(dx); req.b = mag(dx); end
      S_DB:  begin req.a = mag(dy); req.b = mag(dy); end
      S_CA:  begin req.a = mag(wx); req.b = mag(uy); neg = wx[SW-1] ^ uy[SW-1]; end
      S_CB:  begin req.a = mag(wy); req.b = mag(ux); neg = !(wy[SW-1] ^ ux[SW-1]); end
      S_CC:  begin req.a = mag(sacc_r); req.b = mag(sacc_r); end
      S_CD:  begin req.op = OP_DIV; req.a = val_r; req.b = len2_r; end
      S_SQ:  begin req.op = OP_SQRT; req.a = val_r; is_op = !sq_sat; end
      S_FX:  begin req.a = t_r[AW-1:0]; req.b = mag(ux); end
      S_FXD: begin req.op = OP_DIV; req.a = val_r; req.b = len2_r; end
      S_FY:  begin req.a = t_r[AW-1:0]; req.b = mag(uy); end
      S_FYD: begin req.op = OP_DIV; req.a = val_r; req.b = len2_r; end
      default: is_op = 1'b0;
    endcase
    req.start = is_op && !pend_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    qx_nxt = qx_r;  qy_nxt = qy_r;
    x1_nxt = x1_r;  y1_nxt = y1_r;
    x2_nxt = x2_r;  y2_nxt = y2_r;
    nx_nxt = nx_r;  ny_nxt = ny_r;
    best_x_nxt = best_x_r;  best_y_nxt = best_y_r;
    best_d_nxt = best_d_r;  best_i_nxt = best_i_r;
    len2_nxt = len2_r;  val_nxt = val_r;
    sacc_nxt = sacc_r;  t_nxt = t_r;
    near2_nxt = near2_r;  interior_nxt = interior_r;
    d_nxt = d_r;
    o_found_nxt = o_found_r;  o_idx_nxt = o_idx_r;  o_dist_nxt = o_dist_r;
    o_x_nxt = o_x_r;  o_y_nxt = o_y_r;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    in_ch.ready = 1'b0;

    if (is_op) begin
      if (!pend_r) pend_nxt = 1'b1;
      else if (rsp.done) pend_nxt = 1'b0;
    end
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (accept) begin
          unique case (mode_t'(in_ch.mode))
            MODE_CLEAR: cnt_nxt = '0;
            MODE_APPEND: begin
              if (cnt_r < CW'(MAX_VERTICES)) begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            MODE_QUERY: begin
              qx_nxt     = in_ch.coord_x;
              qy_nxt     = in_ch.coord_y;
              found_nxt  = 1'b0;
              best_d_nxt = '0;
              best_i_nxt = '0;
              best_x_nxt = '0;
              best_y_nxt = '0;
              i_nxt      = '0;
              state_nxt  = (cnt_r < CW'(2)) ? S_DONE : S_RD0;
            end
            default: ;
          endcase
        end
      end
      S_RD0: begin
        rd_en     = 1'b1;
        state_nxt = S_LD0;
      end
      S_LD0: begin
        x1_nxt    = rd_data_r[63:32];
        y1_nxt    = rd_data_r[31:0];
        state_nxt = S_RDN;
      end
      S_RDN: begin
        rd_en     = 1'b1;
        rd_addr   = IW'(i_r + CW'(1));
        state_nxt = S_LDN;
      end
      S_LDN: begin
        x2_nxt    = rd_data_r[63:32];
        y2_nxt    = rd_data_r[31:0];
        state_nxt = S_LA;
      end
      S_LA: if (pend_r && rsp.done) begin
        len2_nxt  = rsp.res;
        state_nxt = S_LB;
      end
      S_LB: if (pend_r && rsp.done) begin
        len2_nxt  = lsum;
        state_nxt = (lsum == '0) ? S_NEXT : S_TA;
      end
      S_TA: if (pend_r && rsp.done) begin
        sacc_nxt  = sp;
        state_nxt = S_TB;
      end
      S_TB: if (pend_r && rsp.done) begin
        t_nxt     = tsum;
        state_nxt = S_DA;
        if (tsum[SW-1] || tsum == '0) begin
          near2_nxt    = 1'b0;
          interior_nxt = 1'b0;
          nx_nxt       = x1_r;
          ny_nxt       = y1_r;
        end else if (tsum >= $signed({1'b0, len2_r})) begin
          near2_nxt    = 1'b1;
          interior_nxt = 1'b0;
          nx_nxt       = x2_r;
          ny_nxt       = y2_r;
        end else begin
          interior_nxt = 1'b1;
          state_nxt    = S_CA;
        end
      end
      S_DA: if (pend_r && rsp.done) begin
        val_nxt   = rsp.res;
        state_nxt = S_DB;
      end
      S_DB: if (pend_r && rsp.done) begin
        val_nxt   = val_r + rsp.res;
        state_nxt = S_SQ;
      end
      S_CA: if (pend_r && rsp.done) begin
        sacc_nxt  = sp;
        state_nxt = S_CB;
      end
      S_CB: if (pend_r && rsp.done) begin
        sacc_nxt  = tsum;
        state_nxt = S_CC;
      end
      S_CC: if (pend_r && rsp.done) begin
        val_nxt   = rsp.res;
        state_nxt = S_CD;
      end
      S_CD: if (pend_r && rsp.done) begin
        val_nxt   = rsp.res;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        if (sq_sat) begin
          d_nxt     = DIST_SAT;
          state_nxt = interior_r ? S_FX : S_CMP;
        end else if (pend_r && rsp.done) begin
          d_nxt     = rsp.res[DW-1:0];
          state_nxt = interior_r ? S_FX : S_CMP;
        end
      end
      S_FX: if (pend_r && rsp.done) begin
        val_nxt   = rsp.res;
        state_nxt = S_FXD;
      end
      S_FXD: if (pend_r && rsp.done) begin
        nx_nxt    = foot_sum[31:0];
        state_nxt = S_FY;
      end
      S_FY: if (pend_r && rsp.done) begin
        val_nxt   = rsp.res;
        state_nxt = S_FYD;
      end
      S_FYD: if (pend_r && rsp.done) begin
        ny_nxt    = foot_sum[31:0];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!found_r || d_r < best_d_r) begin
          found_nxt  = 1'b1;
          best_d_nxt = d_r;
          best_i_nxt = 8'(i_r);
          best_x_nxt = nx_r;
          best_y_nxt = ny_r;
        end
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (ip2 < {1'b0, cnt_r}) begin
          i_nxt     = i_r + CW'(1);
          x1_nxt    = x2_r;
          y1_nxt    = y2_r;
          state_nxt = S_RDN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_found_nxt   = found_r;
          o_idx_nxt     = best_i_r;
          o_dist_nxt    = best_d_r;
          o_x_nxt       = best_x_r;
          o_y_nxt       = best_y_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) vmem[cnt_r[IW-1:0]] <= {in_ch.coord_x, in_ch.coord_y};
    if (rd_en) rd_data_r <= vmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    found_r <= found_nxt;
    qx_r <= qx_nxt;  qy_r <= qy_nxt;
    x1_r <= x1_nxt;  y1_r <= y1_nxt;
    x2_r <= x2_nxt;  y2_r <= y2_nxt;
    nx_r <= nx_nxt;  ny_r <= ny_nxt;
    best_x_r <= best_x_nxt;  best_y_r <= best_y_nxt;
    best_d_r <= best_d_nxt;  best_i_r <= best_i_nxt;
    len2_r <= len2_nxt;  val_r <= val_nxt;
    sacc_r <= sacc_nxt;  t_r <= t_nxt;
    near2_r <= near2_nxt;  interior_r <= interior_nxt;
    d_r <= d_nxt;
    o_found_r <= o_found_nxt;  o_idx_r <= o_idx_nxt;  o_dist_r <= o_dist_nxt;
    o_x_r <= o_x_nxt;  o_y_r <= o_y_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = o_found_r;
  assign out_ch.segment_index = o_idx_r;
  assign out_ch.distance      = o_dist_r;
  assign out_ch.nearest_x     = o_x_r;
  assign out_ch.nearest_y     = o_y_r;

  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> pend_r)
    else $error("shared unit finished with no operation pending");

  a_start_pending: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> pend_r)
    else $error("operation start not tracked");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  a_segment_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LDN |-> ({1'b0, i_r} + (CW+1)'(1)) < {1'b0, cnt_r})
    else $error("segment end vertex beyond stored polyline");

endmodule

@@ verif/nearest_polyline_segment_point_core_tb.sv @@
`timescale 1ns / 100ps

module nearest_polyline_segment_point_core_tb import npsp_pkg::*; ();

  localparam int NVERT = 256;
  localparam int CYCLE_LIMIT = 4000000;

  typedef logic signed [139:0] acc_t;

  typedef struct {
    logic        found;
    logic [7:0]  seg;
    logic [30:0] distance;
    logic [31:0] nx;
    logic [31:0] ny;
  } nearest_t;

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   errors = 0;
  int   idle_pct = 29;
  bit   quiet = 1'b0;

  longint   poly_x[NVERT];
  longint   poly_y[NVERT];
  int       poly_len = 0;
  nearest_t nearest_q[$];

  npsp_in_if  in_ch();
  npsp_out_if out_ch();

  nearest_polyline_segment_point_core #(.MAX_VERTICES(NVERT)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= 29);
  end

  function automatic logic [30:0] root_sat(acc_t v);
    longint unsigned x, r, b;
    if (v >= (acc_t'(1) <<< 62)) return '1;
    x = v[63:0];
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[30:0];
  endfunction

  function automatic longint foot_off(longint u, acc_t t, acc_t len2);
    acc_t mu, q;
    mu = (u < 0) ? -u : u;
    q = (mu * t) / len2;
    return (u < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic nearest_t nearest_point(longint qx, longint qy);
    nearest_t res;
    acc_t ux, uy, wx, wy, len2, t, c;
    logic [30:0] d;
    longint nx, ny;
    res = '{1'b0, 8'd0, 31'd0, 32'd0, 32'd0};
    for (int i = 0; i + 1 < poly_len; i++) begin
      ux = poly_x[i+1] - poly_x[i];
      uy = poly_y[i+1] - poly_y[i];
      wx = qx - poly_x[i];
      wy = qy - poly_y[i];
      len2 = ux * ux + uy * uy;
      if (len2 == 0) continue;
      t = wx * ux + wy * uy;
      if (t <= 0) begin
        d = root_sat(wx * wx + wy * wy);
        nx = poly_x[i];
        ny = poly_y[i];
      end else if (t >= len2) begin
        wx = qx - poly_x[i+1];
        wy = qy - poly_y[i+1];
        d = root_sat(wx * wx + wy * wy);
        nx = poly_x[i+1];
        ny = poly_y[i+1];
      end else begin
        c = wx * uy - wy * ux;
        d = root_sat((c * c) / len2);
        nx = poly_x[i] + foot_off(ux, t, len2);
        ny = poly_y[i] + foot_off(uy, t, len2);
      end
      if (!res.found || d < res.distance) begin
        res.found = 1'b1;
        res.distance = d;
        res.seg = i[7:0];
        res.nx = nx[31:0];
        res.ny = ny[31:0];
      end
    end
    return res;
  endfunction

  task automatic send_word(mode_t mode, logic [31:0] x, logic [31:0] y);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    do @(posedge clk); while (!in_ch.ready);
    case (mode)
      MODE_CLEAR: poly_len = 0;
      MODE_APPEND: begin
        if (poly_len < NVERT) begin
          poly_x[poly_len] = longint'($signed(x));
          poly_y[poly_len] = longint'($signed(y));
          poly_len++;
        end
      end
      MODE_QUERY: nearest_q.insert(nearest_q.size(), nearest_point($signed(x), $signed(y)));
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    nearest_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (nearest_q.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = nearest_q.pop_front();
        if (out_ch.found !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, out_ch.found);
          errors++;
        end
        if (out_ch.segment_index !== e.seg) begin
          $error("segment_index: expected %0d, got %0d", e.seg, out_ch.segment_index);
          errors++;
        end
        if (out_ch.distance !== e.distance) begin
          $error("distance: expected %h, got %h", e.distance, out_ch.distance);
          errors++;
        end
        if (out_ch.nearest_x !== e.nx) begin
          $error("nearest_x: expected %h, got %h", e.nx, out_ch.nearest_x);
          errors++;
        end
        if (out_ch.nearest_y !== e.ny) begin
          $error("nearest_y: expected %h, got %h", e.ny, out_ch.nearest_y);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return $urandom_range(7) << 12;
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task automatic test_degenerate();
    send_word(MODE_CLEAR, 0, 0);
    send_word(MODE_QUERY, 32'h1000, 32'h1000);
    send_word(MODE_APPEND, 32'h1000, 32'h2000);
    send_word(MODE_QUERY, 0, 0);
    send_word(MODE_APPEND, 32'h1000, 32'h2000);
    send_word(MODE_QUERY, 0, 0);
    send_word(MODE_NONE, 32'h5000, 32'h5000);
    send_word(MODE_QUERY, 32'hFFFF_F000, 32'h3000);
  endtask

  task automatic test_segment_cases();
    send_word(MODE_CLEAR, 0, 0);
    send_word(MODE_APPEND, 0, 0);
    send_word(MODE_APPEND, 32'h4000, 0);
    send_word(MODE_APPEND, 32'h4000, 32'h4000);
    send_word(MODE_QUERY, 0, 32'h2000);
    send_word(MODE_QUERY, 32'hFFFF_E000, 32'hFFFF_F000);
    send_word(MODE_QUERY, 32'h1800, 32'h0C00);
    send_word(MODE_QUERY, 32'h6000, 32'h6000);
    send_word(MODE_QUERY, 32'h2000, 32'h2000);
  endtask

  task automatic test_extremes();
    send_word(MODE_CLEAR, 0, 0);
    send_word(MODE_APPEND, 32'h8000_0000, 32'h8000_0000);
    send_word(MODE_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(MODE_APPEND, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(MODE_QUERY, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(MODE_QUERY, 32'h8000_0000, 32'h8000_0000);
    send_word(MODE_QUERY, 32'h0000_0001, 32'hFFFF_FFFF);
  endtask

  task automatic test_full_store();
    send_word(MODE_CLEAR, 0, 0);
    for (int i = 0; i <= NVERT; i++) begin
      send_word(MODE_APPEND, 32'($signed($urandom_range(4000)) - 2000),
                32'($signed($urandom_range(4000)) - 2000));
    end
    send_word(MODE_QUERY, 32'd100, 32'hFFFF_FF00);
  endtask

  task automatic test_random();
    int words;
    int nv;
    words = 0;
    while (words < 140) begin
      idle_pct = (words < 40) ? 0 : 29;
      quiet = (words < 40);
      if ($urandom_range(9) == 0) begin
        send_word(mode_t'($urandom_range(3)), $urandom, $urandom);
        words++;
        continue;
      end
      send_word(MODE_CLEAR, $urandom, $urandom);
      nv = $urandom_range(6);
      for (int i = 0; i < nv; i++) begin
        if (i > 0 && $urandom_range(7) == 0)
          send_word(MODE_APPEND, poly_x[poly_len-1][31:0], poly_y[poly_len-1][31:0]);
        else
          send_word(MODE_APPEND, rand_coord(), rand_coord());
      end
      for (int i = $urandom_range(1, 3); i > 0; i--) send_word(MODE_QUERY, rand_coord(), rand_coord());
      words += nv + 3;
    end
    idle_pct = 29;
    quiet = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_CLEAR;
    in_ch.coord_x <= '0;
    in_ch.coord_y <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_degenerate();
    test_segment_cases();
    test_extremes();
    test_full_store();
    test_random();
    in_ch.valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/npsp_pkg.sv
rtl/core/npsp_in_if.sv
rtl/core/npsp_out_if.sv
rtl/core/npsp_alu.sv
rtl/core/nearest_polyline_segment_point_core.sv
verif/nearest_polyline_segment_point_core_tb.sv
